>>> rtl/lsc_pkg.sv
package lsc_pkg;

    localparam int LED_COUNT_DEF = 24;
    localparam int CHAN_W        = 8;
    localparam int LED_IDX_W     = 6;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHASE_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 2'd2;

    localparam logic              CHASE_MODE_RST  = 1'b0;
    localparam logic [CHAN_W-1:0] STEP_SIZE_RST   = 8'd5;
    localparam logic [CHAN_W-1:0] TICK_PERIOD_RST = 8'd25;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } color_t;

endpackage

>>> rtl/led_strip_color_chase.sv
// Color chase for an LED strip of LED_COUNT entries.
// Input channel (s_valid/s_ready/s_tick): one transaction per millisecond tick.
// A tick with s_tick low, or one that does not complete the tick period, is
// accepted and gives no result. Every tick_period-th tick steps the
// color wheel, shifts the color store and streams the whole frame on the
// result channel (m_*): LED_COUNT transactions, index 0 first, m_last_led on
// the final one.
// An update runs through the tick, a priming read of the store, then one entry
// per cycle through the single read port of the color store while the receiver
// keeps up. s_ready stays low from the priming read until the last entry.
// When m_ready is low and the result register is full, the frame sweep holds in
// place; the result register keeps its transaction and no entry is lost.
// Configuration (cfg_*): index 0 chase_mode, 1 step_size, 2 tick_period;
// other indexes are ignored. Write only while the block is idle.
// Reset (aresetn low, synchronous) restores the register defaults, clears the
// wheel and tick count; the store reads as all zero until the first frame has
// rewritten every entry, so no clearing pass is needed.
module led_strip_color_chase #(
    parameter int LED_COUNT = lsc_pkg::LED_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_tick,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lsc_pkg::LED_IDX_W-1:0]     m_led_index,
    output logic [lsc_pkg::CHAN_W-1:0]        m_red,
    output logic [lsc_pkg::CHAN_W-1:0]        m_green,
    output logic [lsc_pkg::CHAN_W-1:0]        m_blue,
    output logic                              m_last_led,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW = $clog2(LED_COUNT);

    logic                          chase_mode_reg;
    logic [lsc_pkg::CHAN_W-1:0]    step_size_reg;
    logic [lsc_pkg::CHAN_W-1:0]    tick_period_reg;
    logic [lsc_pkg::CHAN_W-1:0]    tick_count_reg, tick_count_next;

    logic [lsc_pkg::CHAN_W:0]      count_inc;
    logic [lsc_pkg::CHAN_W-1:0]    period;
    logic                          in_xfer, fire, start, busy;

    lsc_pkg::color_t               wheel_color;
    logic                          mem_we, mem_re;
    logic [AW-1:0]                 mem_waddr, mem_raddr;
    lsc_pkg::color_t               mem_wdata, mem_rdata;

    assign cfg_ready = 1'b1;
    assign s_ready   = !busy;
    assign in_xfer   = s_valid && s_ready;

    always_comb begin
        count_inc = {1'b0, tick_count_reg} + 9'd1;
        // a zero period acts as one
        period    = (tick_period_reg == '0) ? 8'd1 : tick_period_reg;
        fire      = (count_inc >= {1'b0, period});
        start     = in_xfer && s_tick && fire;
        tick_count_next = tick_count_reg;
        if (in_xfer && s_tick) begin
            tick_count_next = fire ? '0 : count_inc[lsc_pkg::CHAN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chase_mode_reg  <= lsc_pkg::CHASE_MODE_RST;
            step_size_reg   <= lsc_pkg::STEP_SIZE_RST;
            tick_period_reg <= lsc_pkg::TICK_PERIOD_RST;
            tick_count_reg  <= '0;
        end else begin
            tick_count_reg <= tick_count_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    lsc_pkg::REG_CHASE_MODE:  chase_mode_reg  <= cfg_data[0];
                    lsc_pkg::REG_STEP_SIZE:   step_size_reg   <= cfg_data;
                    lsc_pkg::REG_TICK_PERIOD: tick_period_reg <= cfg_data;
                    default: begin
                        // drop writes to unknown indexes
                        chase_mode_reg <= chase_mode_reg;
                    end
                endcase
            end
        end
    end

    lsc_wheel u_wheel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (start),
        .step_size (step_size_reg),
        .color     (wheel_color)
    );

    lsc_strip_ram #(
        .DEPTH (LED_COUNT)
    ) u_strip_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lsc_sweep #(
        .LED_COUNT (LED_COUNT)
    ) u_sweep (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .chase_mode  (chase_mode_reg),
        .wheel_color (wheel_color),
        .busy        (busy),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_led_index (m_led_index),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue),
        .m_last_led  (m_last_led)
    );

endmodule

>>> rtl/lsc_strip_ram.sv
module lsc_strip_ram #(
    parameter int DEPTH = lsc_pkg::LED_COUNT_DEF
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  lsc_pkg::color_t            wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output lsc_pkg::color_t            rdata
);

    lsc_pkg::color_t mem [DEPTH];
    lsc_pkg::color_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lsc_wheel.sv
module lsc_wheel (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  logic [lsc_pkg::CHAN_W-1:0]    step_size,
    output lsc_pkg::color_t               color
);

    localparam logic [2:0] PH_RED_UP    = 3'd0;
    localparam logic [2:0] PH_GREEN_UP  = 3'd1;
    localparam logic [2:0] PH_RED_DN    = 3'd2;
    localparam logic [2:0] PH_BLUE_UP   = 3'd3;
    localparam logic [2:0] PH_GREEN_DN  = 3'd4;
    localparam logic [2:0] PH_RED_UP2   = 3'd5;
    localparam logic [2:0] PH_BLUE_DN   = 3'd6;

    function automatic logic [lsc_pkg::CHAN_W-1:0] sat_up(
        input logic [lsc_pkg::CHAN_W-1:0] ch,
        input logic [lsc_pkg::CHAN_W-1:0] st
    );
        logic [lsc_pkg::CHAN_W:0] sum;
        sum = {1'b0, ch} + {1'b0, st};
        return sum[lsc_pkg::CHAN_W] ? lsc_pkg::CHAN_MAX : sum[lsc_pkg::CHAN_W-1:0];
    endfunction

    function automatic logic [lsc_pkg::CHAN_W-1:0] sat_down(
        input logic [lsc_pkg::CHAN_W-1:0] ch,
        input logic [lsc_pkg::CHAN_W-1:0] st
    );
        return (ch > st) ? ch - st : '0;
    endfunction

    logic [2:0]      phase_reg, phase_next;
    lsc_pkg::color_t color_reg, color_next;

    logic [lsc_pkg::CHAN_W-1:0] red_up, red_dn, green_up, green_dn, blue_up, blue_dn;

    always_comb begin
        red_up   = sat_up(color_reg.red, step_size);
        red_dn   = sat_down(color_reg.red, step_size);
        green_up = sat_up(color_reg.green, step_size);
        green_dn = sat_down(color_reg.green, step_size);
        blue_up  = sat_up(color_reg.blue, step_size);
        blue_dn  = sat_down(color_reg.blue, step_size);

        phase_next = phase_reg;
        color_next = color_reg;
        if (step_en) begin
            case (phase_reg)
                PH_RED_UP: begin
                    color_next.red = red_up;
                    if (red_up == lsc_pkg::CHAN_MAX) phase_next = PH_GREEN_UP;
                end
                PH_GREEN_UP: begin
                    color_next.green = green_up;
                    if (green_up == lsc_pkg::CHAN_MAX) phase_next = PH_RED_DN;
                end
                PH_RED_DN: begin
                    color_next.red = red_dn;
                    if (red_dn == '0) phase_next = PH_BLUE_UP;
                end
                PH_BLUE_UP: begin
                    color_next.blue = blue_up;
                    if (blue_up == lsc_pkg::CHAN_MAX) phase_next = PH_GREEN_DN;
                end
                PH_GREEN_DN: begin
                    color_next.green = green_dn;
                    if (green_dn == '0) phase_next = PH_RED_UP2;
                end
                PH_RED_UP2: begin
                    color_next.red = red_up;
                    if (red_up == lsc_pkg::CHAN_MAX) phase_next = PH_BLUE_DN;
                end
                PH_BLUE_DN: begin
                    color_next.blue = blue_dn;
                    if (blue_dn == '0) phase_next = PH_GREEN_UP;
                end
                default: begin
                    // unused code: hold
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_RED_UP;
            color_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            color_reg <= color_next;
        end
    end

    assign color = color_reg;

endmodule

>>> rtl/lsc_sweep.sv
module lsc_sweep #(
    parameter int LED_COUNT = lsc_pkg::LED_COUNT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic                             chase_mode,
    input  lsc_pkg::color_t                  wheel_color,
    output logic                             busy,
    output logic                             mem_we,
    output logic [$clog2(LED_COUNT)-1:0]     mem_waddr,
    output lsc_pkg::color_t                  mem_wdata,
    output logic                             mem_re,
    output logic [$clog2(LED_COUNT)-1:0]     mem_raddr,
    input  lsc_pkg::color_t                  mem_rdata,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [lsc_pkg::LED_IDX_W-1:0]    m_led_index,
    output logic [lsc_pkg::CHAN_W-1:0]       m_red,
    output logic [lsc_pkg::CHAN_W-1:0]       m_green,
    output logic [lsc_pkg::CHAN_W-1:0]       m_blue,
    output logic                             m_last_led
);

    localparam int AW   = $clog2(LED_COUNT);
    localparam int HALF = (LED_COUNT - 1) / 2;
    localparam int LAST = LED_COUNT - 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PRIME = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic            filled_reg, filled_next;
    logic            m_valid_reg, m_valid_next;

    // prev holds old[ptr-1], cur holds old[ptr]; the RAM output holds old[ptr+1]
    lsc_pkg::color_t prev_reg, cur_reg;
    lsc_pkg::color_t out_color_reg;
    logic [AW-1:0]   out_idx_reg;
    logic            out_last_reg;

    lsc_pkg::color_t next_old, new_color;
    logic [AW:0]     ptr_ext, rd_ahead;
    logic            slot_free, at_last, is_lower, emit;

    always_comb begin
        // store reads as zero until the first frame has rewritten every entry
        next_old  = filled_reg ? mem_rdata : '0;
        slot_free = !m_valid_reg || m_ready;
        ptr_ext   = {1'b0, ptr_reg};
        rd_ahead  = ptr_ext + (AW+1)'(2);
        at_last   = (ptr_reg == AW'(LAST));
        is_lower  = (ptr_ext <= (AW+1)'(HALF));
        emit      = (state_reg == ST_EMIT) && slot_free;

        if (ptr_reg == '0) begin
            new_color = wheel_color;
        end else if (!chase_mode) begin
            new_color = prev_reg;
        end else if (at_last) begin
            new_color = wheel_color;
        end else if (is_lower) begin
            new_color = prev_reg;
        end else begin
            new_color = next_old;
        end

        mem_we    = emit;
        mem_waddr = ptr_reg;
        mem_wdata = new_color;
        mem_re    = start || (state_reg == ST_PRIME)
                    || (emit && (rd_ahead < (AW+1)'(LED_COUNT)));
        if (start) begin
            mem_raddr = '0;
        end else if (state_reg == ST_PRIME) begin
            mem_raddr = AW'(1);
        end else begin
            mem_raddr = rd_ahead[AW-1:0];
        end

        state_next   = state_reg;
        ptr_next     = ptr_reg;
        filled_next  = filled_reg;
        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_PRIME;
                    ptr_next   = '0;
                end
            end
            ST_PRIME: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit) begin
                    if (at_last) begin
                        state_next  = ST_IDLE;
                        filled_next = 1'b1;
                    end else begin
                        ptr_next = ptr_reg + AW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ptr_reg     <= '0;
            filled_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            filled_reg  <= filled_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_PRIME) begin
            cur_reg <= next_old;
        end else if (emit) begin
            prev_reg      <= cur_reg;
            cur_reg       <= next_old;
            out_color_reg <= new_color;
            out_idx_reg   <= ptr_reg;
            out_last_reg  <= at_last;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_led_index = lsc_pkg::LED_IDX_W'(out_idx_reg);
    assign m_red       = out_color_reg.red;
    assign m_green     = out_color_reg.green;
    assign m_blue      = out_color_reg.blue;
    assign m_last_led  = out_last_reg;

endmodule
